>>> rtl/cascaded_kalman_yaw_predictor_top_assert.svh
// ----------------------------------------------------------------------------
// Kalman yaw predictor assertion macros
// Concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef CASCADED_KALMAN_YAW_PREDICTOR_TOP_ASSERT_SVH
`define CASCADED_KALMAN_YAW_PREDICTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CKYP_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("ckyp assertion failed");
// next-cycle implication
`define CKYP_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("ckyp assertion failed");
`else
`define CKYP_ASSERT_IMP(lbl, ant, con)
`define CKYP_ASSERT_NXT(lbl, ant, con)
`endif
`endif

>>> rtl/ckyp_pkg.sv
// ----------------------------------------------------------------------------
// Kalman yaw predictor package
// Shared types, widths and a saturation helper function
// ----------------------------------------------------------------------------
package ckyp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SUMW   = 38;  // wide signed sum before saturation
  localparam int MUL_AW = 34;  // signed multiplicand
  localparam int MUL_BW = 32;  // unsigned multiplier, one bit per cycle
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DEN_W  = 33;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEAS, ST_PREP, ST_DIV, ST_MULE, ST_MULV, ST_POST,
    ST_HH, ST_VH, ST_AHH, ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    FLT_POS, FLT_VEL, FLT_ACC, FLT_PRED, FLT_SPIN
  } filt_e;

  typedef enum logic [2:0] {
    REG_HORIZON, REG_BIAS, REG_PROC_NOISE, REG_POS_NOISE,
    REG_VEL_NOISE, REG_ACC_NOISE, REG_PRED_NOISE, REG_SPIN_NOISE
  } cfg_reg_e;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] v);
    logic signed [31:0] r;
    if ((&v[SUMW-1:31]) || !(|v[SUMW-1:31])) begin
      r = v[31:0];
    end else if (v[SUMW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

>>> rtl/ckyp_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed by unsigned shift-add, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ckyp_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [ckyp_pkg::MUL_AW-1:0]    a_i,
  input  logic        [ckyp_pkg::MUL_BW-1:0]    b_i,
  output ckyp_pkg::unit_stat_t                  stat_o,
  output logic signed [ckyp_pkg::MUL_PW-1:0]    prod_o
);
  import ckyp_pkg::*;

  localparam int CW = $clog2(MUL_BW + 1);

  logic signed [MUL_PW-1:0] acc_q, acc_d, a_q, a_d;
  logic        [MUL_BW-1:0] b_q, b_d;
  logic        [CW-1:0]     cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  // shift-add step
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = MUL_PW'(a_i);
      b_d    = b_i;
      cnt_d  = CW'(MUL_BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

>>> rtl/ckyp_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ckyp_div #(
  parameter int NW = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [NW-1:0]                    num_i,
  input  logic [ckyp_pkg::DEN_W-1:0]       den_i,
  output ckyp_pkg::unit_stat_t             stat_o,
  output logic [NW-1:0]                    quot_o
);
  import ckyp_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[NW-1]};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

>>> rtl/cascaded_kalman_yaw_predictor_top.sv
// Each filter takes one gain division (skipped when the denominator is zero) and two
// products on a shared bit-serial divider and multiplier, plus three horizon products.
// One beat is worked at a time; the next is taken once the result is registered.
// Reset (async, active low) restores registers and filter state to defaults.
`include "cascaded_kalman_yaw_predictor_top_assert.svh"
// ----------------------------------------------------------------------------
// Cascaded Kalman yaw predictor
// Position, velocity, acceleration, prediction and spin centre filters
// ----------------------------------------------------------------------------
module cascaded_kalman_yaw_predictor_top #(
  parameter int FRACTION_BITS = ckyp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [24:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // gimbal_yaw[31:0], target_offset[56:32], zero fill
  input  logic [1:0]   s_axis_tuser,   // spin_mode[0], clear_history[1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // filtered_yaw[31:0], yaw_rate[49:32],
                                       // yaw_accel[61:50], predicted_yaw[93:62],
                                       // spin_center[125:94], zero fill
);
  import ckyp_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int NW = 32 + F;
  localparam logic [31:0] ONE_U       = 32'(64'd1 << F);
  localparam logic signed [31:0] ONE_S = 32'(64'd1 << F);
  localparam logic signed [31:0] ACC_LIM = 32'(((64'd2 << F) + 64'd50) / 64'd100);
  localparam logic [31:0] POS_VAR_RST = 32'(((64'd27 << F) + 64'd5) / 64'd10);
  localparam logic [31:0] VEL_VAR_RST = 32'(((64'd62 << F) + 64'd50) / 64'd100);
  localparam logic [31:0] PRED_VAR_RST = 32'(64'd4 << F);

  st_e   state_q, state_d;
  filt_e fi_q;

  // configuration
  logic        [15:0] horizon_q;
  logic signed [24:0] bias_q;
  logic        [23:0] qn_q, r_pos_q, r_vel_q, r_acc_q, r_pred_q, r_spin_q;

  // filter state
  logic signed [31:0] est_q [5];
  logic        [31:0] var_q [5];
  logic signed [31:0] prev_pos_q, prev_vel_q;

  // per-beat working registers
  logic signed [31:0] gimbal_q, x_q;
  logic signed [24:0] off_q;
  logic               spin_q, clr_q;
  logic        [31:0] p_q, hh_q;
  logic        [F:0]  k_q;
  logic signed [SUMW-1:0] t1_q;

  // output register
  logic                m_valid_q;
  logic signed [31:0]  o_yaw_q, o_pred_q, o_spin_q;
  logic        [17:0]  o_rate_q;
  logic        [11:0]  o_acc_q;

  // shared units
  logic                     mul_start, div_start;
  logic signed [MUL_AW-1:0] mul_a;
  logic        [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_prod;
  unit_stat_t               mul_stat, div_stat;
  logic        [NW-1:0]     div_quot;

  // combinational helpers
  logic signed [31:0]     est_sel, v_clamp, a_clamp, pos_now;
  logic        [31:0]     var_sel;
  logic        [23:0]     r_sel;
  logic        [32:0]     psum, den_now;
  logic        [31:0]     p_now;
  logic        [F:0]      k_now;
  logic signed [26:0]     off3;
  logic signed [SUMW-1:0] meas_sum, est_sum, pin_sum, prod_f;
  logic                   in_hs, out_hs, out_free;

  assign in_hs    = s_axis_tvalid && s_axis_tready;
  assign out_hs   = m_axis_tvalid && m_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= 16'd3456;
      bias_q    <= 25'sd32768;
      qn_q      <= 24'd65536;
      r_pos_q   <= 24'd655360;
      r_vel_q   <= 24'd65536;
      r_acc_q   <= 24'd2621440;
      r_pred_q  <= 24'd1310720;
      r_spin_q  <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HORIZON:    horizon_q <= cfg_data_i[15:0];
        REG_BIAS:       bias_q    <= cfg_data_i;
        REG_PROC_NOISE: qn_q      <= cfg_data_i[23:0];
        REG_POS_NOISE:  r_pos_q   <= cfg_data_i[23:0];
        REG_VEL_NOISE:  r_vel_q   <= cfg_data_i[23:0];
        REG_ACC_NOISE:  r_acc_q   <= cfg_data_i[23:0];
        REG_PRED_NOISE: r_pred_q  <= cfg_data_i[23:0];
        REG_SPIN_NOISE: r_spin_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // selected filter operands
  always_comb begin
    case (fi_q)
      FLT_POS:  r_sel = r_pos_q;
      FLT_VEL:  r_sel = r_vel_q;
      FLT_ACC:  r_sel = r_acc_q;
      FLT_PRED: r_sel = r_pred_q;
      FLT_SPIN: r_sel = r_spin_q;
      default:  r_sel = r_pos_q;
    endcase
  end

  assign est_sel = est_q[fi_q];
  assign var_sel = var_q[fi_q];
  assign pos_now = est_q[FLT_POS];

  // predicted variance, saturated, and gain denominator
  assign psum    = {1'b0, var_sel} + {9'd0, qn_q};
  assign p_now   = psum[32] ? 32'hffff_ffff : psum[31:0];
  assign den_now = {1'b0, p_now} + {9'd0, r_sel};
  assign k_now   = (state_q == ST_PREP) ? (F+1)'(ONE_U) : div_quot[F:0];

  // measurement: gimbal + 1.5 * offset + bias
  assign off3     = 27'(off_q) + (27'(off_q) <<< 1);
  assign meas_sum = SUMW'(gimbal_q) + SUMW'(off3 >>> 1) + SUMW'(bias_q);

  // estimate update and horizon sum
  assign prod_f  = SUMW'(mul_prod >>> F);
  assign est_sum = SUMW'(est_sel) + prod_f;
  assign pin_sum = SUMW'(pos_now) + t1_q + SUMW'(mul_prod >>> 17);

  // velocity and acceleration clamps
  always_comb begin
    if (est_sel > ONE_S) begin
      v_clamp = ONE_S;
    end else if (est_sel < -ONE_S) begin
      v_clamp = -ONE_S;
    end else begin
      v_clamp = est_sel;
    end
    if (est_sel > ACC_LIM) begin
      a_clamp = ACC_LIM;
    end else if (est_sel < -ACC_LIM) begin
      a_clamp = -ACC_LIM;
    end else begin
      a_clamp = est_sel;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_hs) state_d = ST_MEAS;
      ST_MEAS: state_d = ST_PREP;
      ST_PREP: state_d = (den_now == '0) ? ST_MULE : ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_MULE;
      ST_MULE: if (mul_stat.done) state_d = ST_MULV;
      ST_MULV: if (mul_stat.done) state_d = ST_POST;
      ST_POST: begin
        case (fi_q)
          FLT_POS, FLT_VEL: state_d = ST_PREP;
          FLT_ACC:          state_d = ST_HH;
          FLT_PRED:         state_d = spin_q ? ST_PREP : ST_OUT;
          default:          state_d = ST_OUT;
        endcase
      end
      ST_HH:   if (mul_stat.done) state_d = ST_VH;
      ST_VH:   if (mul_stat.done) state_d = ST_AHH;
      ST_AHH:  if (mul_stat.done) state_d = ST_PREP;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // unit starts and operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      ST_PREP: begin
        if (den_now == '0) begin
          mul_start = 1'b1;
          mul_a     = MUL_AW'(x_q) - MUL_AW'(est_sel);
          mul_b     = MUL_BW'(k_now);
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        mul_start = div_stat.done;
        mul_a     = MUL_AW'(x_q) - MUL_AW'(est_sel);
        mul_b     = MUL_BW'(k_now);
      end
      ST_MULE: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_AW'({2'b00, p_q});
        mul_b     = ONE_U - MUL_BW'(k_q);
      end
      ST_POST: begin
        mul_start = (fi_q == FLT_ACC);
        mul_a     = MUL_AW'({18'd0, horizon_q});
        mul_b     = MUL_BW'(horizon_q);
      end
      ST_HH: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_AW'(est_q[FLT_VEL]);
        mul_b     = MUL_BW'(horizon_q);
      end
      ST_VH: begin
        mul_start = mul_stat.done;
        mul_a     = MUL_AW'(est_q[FLT_ACC]);
        mul_b     = hh_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fi_q      <= FLT_POS;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MEAS) begin
        fi_q <= FLT_POS;
      end else if (state_q == ST_POST) begin
        case (fi_q)
          FLT_POS:  fi_q <= FLT_VEL;
          FLT_VEL:  fi_q <= FLT_ACC;
          FLT_PRED: fi_q <= FLT_SPIN;
          default:  fi_q <= fi_q;
        endcase
      end else if (state_q == ST_AHH && mul_stat.done) begin
        fi_q <= FLT_PRED;
      end
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (out_hs) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) est_q[i] <= '0;
      var_q[FLT_POS]  <= POS_VAR_RST;
      var_q[FLT_VEL]  <= VEL_VAR_RST;
      var_q[FLT_ACC]  <= ONE_U;
      var_q[FLT_PRED] <= PRED_VAR_RST;
      var_q[FLT_SPIN] <= VEL_VAR_RST;
      prev_pos_q <= '0;
      prev_vel_q <= '0;
    end else begin
      case (state_q)
        ST_MULE: if (mul_stat.done) est_q[fi_q] <= sat32(est_sum);
        ST_MULV: if (mul_stat.done) var_q[fi_q] <= 32'(mul_prod >>> F);
        ST_POST: begin
          if (fi_q == FLT_VEL) est_q[FLT_VEL] <= v_clamp;
          if (fi_q == FLT_ACC) est_q[FLT_ACC] <= a_clamp;
        end
        ST_OUT: begin
          if (out_free) begin
            prev_pos_q <= clr_q ? '0 : pos_now;
            prev_vel_q <= clr_q ? '0 : est_q[FLT_VEL];
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      gimbal_q <= s_axis_tdata[31:0];
      off_q    <= s_axis_tdata[56:32];
      spin_q   <= s_axis_tuser[0];
      clr_q    <= s_axis_tuser[1];
    end
    case (state_q)
      ST_MEAS: x_q <= sat32(meas_sum);
      ST_PREP: begin
        p_q <= p_now;
        if (den_now == '0) k_q <= k_now;
      end
      ST_DIV: if (div_stat.done) k_q <= k_now;
      ST_POST: begin
        case (fi_q)
          FLT_POS:  x_q <= sat32(SUMW'(pos_now) - SUMW'(prev_pos_q));
          FLT_VEL:  x_q <= sat32(SUMW'(v_clamp) - SUMW'(prev_vel_q));
          FLT_PRED: x_q <= pos_now;
          default:  x_q <= x_q;
        endcase
      end
      ST_HH:  if (mul_stat.done) hh_q <= mul_prod[31:0];
      ST_VH:  if (mul_stat.done) t1_q <= SUMW'(mul_prod >>> 8);
      ST_AHH: if (mul_stat.done) x_q <= sat32(pin_sum);
      default: ;
    endcase
    if (state_q == ST_OUT && out_free) begin
      o_yaw_q  <= pos_now;
      o_rate_q <= est_q[FLT_VEL][17:0];
      o_acc_q  <= est_q[FLT_ACC][11:0];
      o_pred_q <= est_q[FLT_PRED];
      o_spin_q <= spin_q ? est_q[FLT_SPIN] : pos_now;
    end
  end

  ckyp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  ckyp_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({p_now, F'(0)}),
    .den_i   (den_now),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, o_spin_q, o_pred_q, o_acc_q, o_rate_q, o_yaw_q};

  // a taken beat always leaves idle
  `CKYP_ASSERT_NXT(a_accept_busy, in_hs, state_q != ST_IDLE)
  // shared units are never restarted while busy
  `CKYP_ASSERT_IMP(a_mul_free, mul_start, !mul_stat.busy)
  `CKYP_ASSERT_IMP(a_div_free, div_start, !div_stat.busy)
  // the gain never exceeds one
  `CKYP_ASSERT_IMP(a_gain_le_one, state_q == ST_MULV, MUL_BW'(k_q) <= ONE_U)

endmodule

>>> tb/sv/tb_cascaded_kalman_yaw_predictor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kalman yaw predictor testbench
// Drives measurement beats through the filter cascade under several register
// settings and handshake pressures, and checks every result beat field by
// field against an in-bench fixed-point model of the five filters.
// ----------------------------------------------------------------------------
module tb_cascaded_kalman_yaw_predictor_top;
  import ckyp_pkg::*;

  localparam longint ONE_Q     = 64'sd65536;
  localparam longint ACC_LIMIT = 64'sd1311;
  localparam int     N_PHASES  = 6;
  localparam int     PHASE_LEN = 100;

  typedef struct {
    logic [31:0] yaw;
    logic [17:0] rate;
    logic [11:0] accel;
    logic [31:0] pred;
    logic [31:0] spin;
  } yaw_res_t;

  typedef struct {
    logic [31:0] gimbal;
    logic [24:0] offset;
    logic        spin;
    logic        clr;
    logic        typed;
    yaw_res_t    res;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [24:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  // filter state and register shadow
  longint          est_r[5];
  longint unsigned var_r[5];
  longint          prev_pos_r;
  longint          prev_vel_r;
  longint unsigned horizon_r;
  longint          bias_r;
  longint unsigned noise_r[8];

  yaw_res_t expected_q[$];
  int       err_cnt;
  int       beats_in;
  int       beats_out;
  int       idle_mode;
  int       hold_cnt;
  logic [31:0] traj_yaw;
  logic [31:0] traj_rate;

  cascaded_kalman_yaw_predictor_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one scalar kalman update of filter f
  function automatic longint kalman_update(filt_e f, longint unsigned r, longint x);
    longint unsigned p;
    longint unsigned den;
    longint unsigned k;
    p = var_r[f] + noise_r[REG_PROC_NOISE];
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + r;
    k = (den == 0) ? 64'd65536 : (p << 16) / den;
    est_r[f] = sat_s32(est_r[f] + ((longint'(k) * (x - est_r[f])) >>> 16));
    var_r[f] = ((64'd65536 - k) * p) >> 16;
    return est_r[f];
  endfunction

  function automatic void reset_filters();
    foreach (est_r[i]) est_r[i] = 0;
    var_r[FLT_POS]  = 176947;
    var_r[FLT_VEL]  = 40632;
    var_r[FLT_ACC]  = 65536;
    var_r[FLT_PRED] = 262144;
    var_r[FLT_SPIN] = 40632;
    prev_pos_r = 0;
    prev_vel_r = 0;
    horizon_r = 3456;
    bias_r = 32768;
    noise_r[REG_PROC_NOISE] = 65536;
    noise_r[REG_POS_NOISE]  = 655360;
    noise_r[REG_VEL_NOISE]  = 65536;
    noise_r[REG_ACC_NOISE]  = 2621440;
    noise_r[REG_PRED_NOISE] = 1310720;
    noise_r[REG_SPIN_NOISE] = 65536;
  endfunction

  // run the cascade for one measurement beat
  function automatic yaw_res_t predict_yaw(logic [31:0] g, logic [24:0] off,
                                           logic spin, logic clr);
    longint   meas, pos, v, a, pin, pred, sc, h;
    yaw_res_t res;
    h = longint'(horizon_r);
    meas = sat_s32(longint'($signed(g)) + ((3 * longint'($signed(off))) >>> 1) + bias_r);
    pos = kalman_update(FLT_POS, noise_r[REG_POS_NOISE], meas);
    v = kalman_update(FLT_VEL, noise_r[REG_VEL_NOISE], sat_s32(pos - prev_pos_r));
    v = clamp_sym(v, ONE_Q);
    est_r[FLT_VEL] = v;
    a = kalman_update(FLT_ACC, noise_r[REG_ACC_NOISE], sat_s32(v - prev_vel_r));
    a = clamp_sym(a, ACC_LIMIT);
    est_r[FLT_ACC] = a;
    pin = sat_s32(pos + ((v * h) >>> 8) + ((a * (h * h)) >>> 17));
    pred = kalman_update(FLT_PRED, noise_r[REG_PRED_NOISE], pin);
    sc = spin ? kalman_update(FLT_SPIN, noise_r[REG_SPIN_NOISE], pos) : pos;
    prev_pos_r = clr ? 0 : pos;
    prev_vel_r = clr ? 0 : v;
    res.yaw   = pos[31:0];
    res.rate  = v[17:0];
    res.accel = a[11:0];
    res.pred  = pred[31:0];
    res.spin  = sc[31:0];
    return res;
  endfunction

  task automatic cfg_write(cfg_reg_e idx, logic [24:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_HORIZON: horizon_r = {48'd0, val[15:0]};
      REG_BIAS:    bias_r = longint'($signed(val));
      default:     noise_r[idx] = {40'd0, val[23:0]};
    endcase
  endtask

  task automatic cfg_all(logic [24:0] h, logic [24:0] b, logic [24:0] q,
                         logic [24:0] r_pos, logic [24:0] r_vel, logic [24:0] r_acc,
                         logic [24:0] r_pred, logic [24:0] r_spin);
    cfg_write(REG_HORIZON, h);
    cfg_write(REG_BIAS, b);
    cfg_write(REG_PROC_NOISE, q);
    cfg_write(REG_POS_NOISE, r_pos);
    cfg_write(REG_VEL_NOISE, r_vel);
    cfg_write(REG_ACC_NOISE, r_acc);
    cfg_write(REG_PRED_NOISE, r_pred);
    cfg_write(REG_SPIN_NOISE, r_spin);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // offer one measurement beat, predict once it is taken
  task automatic send_beat(logic [31:0] g, logic [24:0] off, logic spin, logic clr,
                           logic typed, yaw_res_t typed_res);
    int       gap;
    yaw_res_t res;
    gap = 0;
    if (idle_mode == 1 || idle_mode == 3)
      while ($urandom_range(99) < ((idle_mode == 1) ? 63 : 6)) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  = {7'b0, off, g};
    s_axis_tuser  = {clr, spin};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_yaw(g, off, spin, clr);
    expected_q.push_back(typed ? typed_res : res);
    beats_in++;
  endtask

  task automatic send_random();
    logic [31:0] g;
    logic [24:0] off;
    yaw_res_t    none;
    none = '{default: '0};
    if ($urandom_range(99) < 85) begin
      // smooth target track with small camera offsets
      traj_yaw = traj_yaw + traj_rate;
      if ($urandom_range(19) == 0) traj_rate = $signed($urandom_range(8192)) - 4096;
      g = traj_yaw + ($signed($urandom_range(512)) - 256);
      off = 25'($signed($urandom_range(2097152)) - 1048576);
    end else begin
      g = $urandom;
      off = 25'($urandom);
    end
    send_beat(g, off, 1'($urandom_range(1)), ($urandom_range(19) == 0), 1'b0, none);
  endtask

  // receiver: random stalls and a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(99) >= 63);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(99) >= 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    yaw_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        err_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.yaw) begin
          $error("filtered_yaw expected %h got %h", exp_r.yaw, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[49:32] !== exp_r.rate) begin
          $error("yaw_rate expected %h got %h", exp_r.rate, m_axis_tdata[49:32]);
          err_cnt++;
        end
        if (m_axis_tdata[61:50] !== exp_r.accel) begin
          $error("yaw_accel expected %h got %h", exp_r.accel, m_axis_tdata[61:50]);
          err_cnt++;
        end
        if (m_axis_tdata[93:62] !== exp_r.pred) begin
          $error("predicted_yaw expected %h got %h", exp_r.pred, m_axis_tdata[93:62]);
          err_cnt++;
        end
        if (m_axis_tdata[125:94] !== exp_r.spin) begin
          $error("spin_center expected %h got %h", exp_r.spin, m_axis_tdata[125:94]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tbl[$];
    int       wait_cnt;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_HORIZON;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    err_cnt   = 0;
    beats_in  = 0;
    beats_out = 0;
    idle_mode = 0;
    hold_cnt  = 0;
    traj_yaw  = 32'h0010_0000;
    traj_rate = 32'h0000_0400;
    reset_filters();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero noise and horizon: each filter takes the measurement as is,
    // and the zero-denominator gain of one comes into play
    cfg_all(25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0);
    dir_tbl = '{
      '{32'h0000_0100, 25'h0000000, 1'b0, 1'b1, 1'b1,
        '{32'h100, 18'h100, 12'h100, 32'h100, 32'h100}},
      // positive saturation, both clamps
      '{32'h7FFF_FFFF, 25'h0B40000, 1'b1, 1'b1, 1'b1,
        '{32'h7FFF_FFFF, 18'h10000, 12'd1311, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
      // negative saturation, both clamps
      '{32'h8000_0000, 25'h14C0000, 1'b1, 1'b1, 1'b1,
        '{32'h8000_0000, 18'h30000, 12'hAE1, 32'h8000_0000, 32'h8000_0000}},
      '{32'h0000_0000, 25'h0000000, 1'b0, 1'b0, 1'b1, '{'0, '0, '0, '0, '0}},
      '{32'h0000_0000, 25'h0000001, 1'b0, 1'b0, 1'b0, '{default: '0}},
      '{32'h0000_0000, 25'h1FFFFFF, 1'b1, 1'b0, 1'b0, '{default: '0}},
      '{32'h5555_5555, 25'h0AAAAAA, 1'b0, 1'b0, 1'b0, '{default: '0}},
      '{32'hAAAA_AAAA, 25'h1555555, 1'b1, 1'b0, 1'b0, '{default: '0}},
      '{32'h7FFF_FFFF, 25'h0FFFFFF, 1'b0, 1'b0, 1'b0, '{default: '0}},
      '{32'h8000_0000, 25'h1000000, 1'b1, 1'b1, 1'b0, '{default: '0}},
      '{32'hFFFF_FFFF, 25'h1FFFFFF, 1'b0, 1'b0, 1'b0, '{default: '0}}
    };
    foreach (dir_tbl[i])
      send_beat(dir_tbl[i].gimbal, dir_tbl[i].offset, dir_tbl[i].spin, dir_tbl[i].clr,
                dir_tbl[i].typed, dir_tbl[i].res);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();

    // random phases, each under its own register setting and one of four idling styles
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: cfg_all(25'd3456, 25'd32768, 25'd65536, 25'd655360, 25'd65536,
                   25'd2621440, 25'd1310720, 25'd65536);
        1: cfg_all(25'h000FFFF, 25'h0FFFFFF, 25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF,
                   25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF);
        2: cfg_all(25'd0, 25'h1000000, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0);
        default: cfg_all(25'($urandom), 25'($urandom), 25'($urandom_range(262144)),
                         25'($urandom), 25'($urandom_range(1048576)), 25'($urandom),
                         25'($urandom_range(4194304)), 25'($urandom_range(1048576)));
      endcase
      idle_mode = ph % 4;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 2 && n == 40) hold_cnt = 3000;
        if (ph == 4 && n == 50) begin
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          wait_drained();
        end
        send_random();
      end
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      wait_drained();
    end

    idle_mode = 0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 100000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (1000) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      err_cnt++;
    end
    $display("covered %0d measurement beats, %0d results, %0d register settings",
             beats_in, beats_out, N_PHASES + 1);
    $display("idling styles: none, sender gaps, receiver stalls, both; long hold-off");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
